// ===== design/salc_pkg.sv =====
// Shared constants, types and width helpers for the set-associative LRU lookup core.
`default_nettype none

package salc_pkg;

   // Default geometry.
   localparam int WAYS_DEF       = 4;
   localparam int SETS_DEF       = 64;
   localparam int LINE_BYTES_DEF = 32;
   localparam int ADDR_BITS_DEF  = 32;

   // Width of the address port.
   localparam int ADDR_IN_W = 32;

   // Entries in the request queue between front and back (power of two).
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      BACK_CLEAR,
      BACK_IDLE,
      BACK_UPDATE
   } back_state_type;

   function automatic int idx_width(input int sets);
      return (sets > 1) ? $clog2(sets) : 1;
   endfunction

   function automatic int way_width(input int ways);
      return (ways > 1) ? $clog2(ways) : 1;
   endfunction

   // Tag bits left above the set index within the used part of the address.
   function automatic int tag_width(input int sets, input int line_bytes, input int addr_bits);
      int eff;
      int w;
      eff = (addr_bits < ADDR_IN_W) ? addr_bits : ADDR_IN_W;
      w   = eff - $clog2(line_bytes) - $clog2(sets);
      return (w < 1) ? 1 : w;
   endfunction

endpackage

`default_nettype wire

// ===== design/salc_front.sv =====
// Front end: take requests, split the address into set and tag, and queue them.
`default_nettype none

module salc_front #(
   parameter int WAYS       = salc_pkg::WAYS_DEF,
   parameter int SETS       = salc_pkg::SETS_DEF,
   parameter int LINE_BYTES = salc_pkg::LINE_BYTES_DEF,
   parameter int ADDR_BITS  = salc_pkg::ADDR_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [salc_pkg::ADDR_IN_W-1:0]       req_address,
   input  wire logic                                 clear_active,
   output logic                                      q_valid,
   input  wire logic                                 q_pop,
   output logic [salc_pkg::idx_width(SETS)-1:0]      q_set,
   output logic [salc_pkg::tag_width(SETS, LINE_BYTES, ADDR_BITS)-1:0] q_tag
);

   localparam int AW     = salc_pkg::ADDR_IN_W;
   localparam int IDX_W  = salc_pkg::idx_width(SETS);
   localparam int TAG_W  = salc_pkg::tag_width(SETS, LINE_BYTES, ADDR_BITS);
   localparam int OFF_W  = $clog2(LINE_BYTES);
   localparam int IDX_SH = $clog2(SETS);
   localparam int QD     = salc_pkg::QUEUE_DEPTH;
   localparam int PTR_W  = (QD > 1) ? $clog2(QD) : 1;
   localparam int CNT_W  = $clog2(QD + 1);
   localparam logic [AW-1:0] ADDR_MASK =
      (ADDR_BITS >= AW) ? {AW{1'b1}} : ~({AW{1'b1}} << ADDR_BITS);
   localparam logic [IDX_W-1:0] SET_MASK = IDX_W'(SETS - 1);

   logic [AW-1:0]    addr_used;
   logic [AW-1:0]    line_num;
   logic [IDX_W-1:0] set_dec;
   logic [TAG_W-1:0] tag_dec;
   logic             push;

   logic [IDX_W-1:0] q_set_ff [QD];
   logic [TAG_W-1:0] q_tag_ff [QD];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Drop address bits above the used width, then strip the line offset.
   always_comb begin
      addr_used = req_address & ADDR_MASK;
      line_num  = addr_used >> OFF_W;
      set_dec   = IDX_W'(line_num) & SET_MASK;
      tag_dec   = TAG_W'(line_num >> IDX_SH);
   end

   assign busy    = (count_ff == CNT_W'(QD)) || clear_active;
   assign push    = start && !busy;
   assign q_valid = (count_ff != '0);
   assign q_set   = q_set_ff[rd_ptr_ff];
   assign q_tag   = q_tag_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_set_ff[wr_ptr_ff] <= set_dec;
         q_tag_ff[wr_ptr_ff] <= tag_dec;
      end
   end

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("request popped from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QD))
      else $error("request queue overfilled");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue count missed a push");

endmodule

`default_nettype wire

// ===== design/salc_back.sv =====
// Back end: set row store, tag compare, LRU update and response register.
`default_nettype none

module salc_back #(
   parameter int WAYS       = salc_pkg::WAYS_DEF,
   parameter int SETS       = salc_pkg::SETS_DEF,
   parameter int LINE_BYTES = salc_pkg::LINE_BYTES_DEF,
   parameter int ADDR_BITS  = salc_pkg::ADDR_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   output logic                                      clear_active,
   input  wire logic                                 q_valid,
   output logic                                      q_pop,
   input  wire logic [salc_pkg::idx_width(SETS)-1:0] q_set,
   input  wire logic [salc_pkg::tag_width(SETS, LINE_BYTES, ADDR_BITS)-1:0] q_tag,
   output logic                                      rsp_valid,
   output logic                                      rsp_hit,
   output logic [1:0]                                rsp_way,
   output logic                                      rsp_evicted
);

   localparam int IDX_W   = salc_pkg::idx_width(SETS);
   localparam int TAG_W   = salc_pkg::tag_width(SETS, LINE_BYTES, ADDR_BITS);
   localparam int WAY_W   = salc_pkg::way_width(WAYS);
   localparam int RANK_W  = WAY_W;
   localparam int RANK_LSB = WAYS;
   localparam int TAG_LSB  = WAYS + WAYS * RANK_W;
   localparam int ROW_W    = WAYS * (1 + RANK_W + TAG_W);
   localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);
   localparam logic [IDX_W-1:0]  LAST_SET = IDX_W'(SETS - 1);

   salc_pkg::back_state_type state_ff, state_in;

   // One row per set: valid bits, ranks, tags.
   logic [ROW_W-1:0]  row_mem [SETS];
   logic [ROW_W-1:0]  row_rd_ff;
   logic [ROW_W-1:0]  new_row;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [ROW_W-1:0]  mem_wdata;

   logic [IDX_W-1:0]  clr_idx_ff, clr_idx_in;
   logic [IDX_W-1:0]  cur_set_ff;
   logic [TAG_W-1:0]  cur_tag_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff;
   logic [1:0]        rsp_way_ff;
   logic              rsp_evicted_ff;

   logic [WAYS-1:0]   way_valid;
   logic [RANK_W-1:0] way_rank [WAYS];
   logic [TAG_W-1:0]  way_tag  [WAYS];
   logic [WAYS-1:0]   hit_vec, hit_oh;
   logic [WAYS-1:0]   free_vec, free_oh;
   logic [WAYS-1:0]   victim_oh;
   logic [WAY_W-1:0]  hit_idx, free_idx, victim_idx, chosen_idx;
   logic [RANK_W-1:0] limit;
   logic              limit_all;
   logic              is_hit, is_evict;

   // Unpack the row read for the current request.
   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         way_valid[i] = row_rd_ff[i];
         way_rank[i]  = row_rd_ff[RANK_LSB + i * RANK_W +: RANK_W];
         way_tag[i]   = row_rd_ff[TAG_LSB + i * TAG_W +: TAG_W];
      end
   end

   // Compare all ways at once; pick lowest hit, lowest free way, and the
   // lowest-numbered way holding the oldest rank.
   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         hit_vec[i]   = way_valid[i] && (way_tag[i] == cur_tag_ff);
         victim_oh[i] = 1'b1;
         for (int j = 0; j < WAYS; j++) begin
            if (j < i && way_rank[j] >= way_rank[i]) begin
               victim_oh[i] = 1'b0;
            end
            if (j > i && way_rank[j] > way_rank[i]) begin
               victim_oh[i] = 1'b0;
            end
         end
      end
      free_vec = ~way_valid;
      hit_oh   = hit_vec & (~hit_vec + WAYS'(1));
      free_oh  = free_vec & (~free_vec + WAYS'(1));
      hit_idx    = '0;
      free_idx   = '0;
      victim_idx = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (hit_oh[i])    hit_idx    = hit_idx    | WAY_W'(i);
         if (free_oh[i])   free_idx   = free_idx   | WAY_W'(i);
         if (victim_oh[i]) victim_idx = victim_idx | WAY_W'(i);
      end
   end

   // Choose the way and the rank limit below which other ways age.
   always_comb begin
      is_hit    = |hit_vec;
      is_evict  = 1'b0;
      limit_all = 1'b0;
      priority if (is_hit) begin
         chosen_idx = hit_idx;
         limit      = way_rank[hit_idx];
      end else if (|free_vec) begin
         chosen_idx = free_idx;
         limit      = RANK_MAX;
         limit_all  = 1'b1;
      end else begin
         chosen_idx = victim_idx;
         limit      = way_rank[victim_idx];
         is_evict   = 1'b1;
      end
   end

   // Build the updated row: chosen way becomes newest, younger ways age.
   always_comb begin
      new_row = row_rd_ff;
      for (int i = 0; i < WAYS; i++) begin
         if (WAY_W'(i) == chosen_idx) begin
            new_row[i]                                 = 1'b1;
            new_row[RANK_LSB + i * RANK_W +: RANK_W]   = '0;
            new_row[TAG_LSB + i * TAG_W +: TAG_W]      = cur_tag_ff;
         end else if (way_valid[i] && (limit_all || way_rank[i] < limit)
                      && way_rank[i] < RANK_MAX) begin
            new_row[RANK_LSB + i * RANK_W +: RANK_W]   = way_rank[i] + RANK_W'(1);
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         salc_pkg::BACK_CLEAR: begin
            if (clr_idx_ff == LAST_SET) state_in = salc_pkg::BACK_IDLE;
         end
         salc_pkg::BACK_IDLE: begin
            if (q_valid) state_in = salc_pkg::BACK_UPDATE;
         end
         salc_pkg::BACK_UPDATE: begin
            state_in = salc_pkg::BACK_IDLE;
         end
         default: begin
            state_in = salc_pkg::BACK_CLEAR;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      clear_active = 1'b0;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = cur_set_ff;
      mem_wdata    = new_row;
      rsp_valid_in = 1'b0;
      clr_idx_in   = clr_idx_ff;
      unique case (state_ff)
         salc_pkg::BACK_CLEAR: begin
            clear_active = 1'b1;
            mem_we       = 1'b1;
            mem_waddr    = clr_idx_ff;
            mem_wdata    = '0;
            clr_idx_in   = clr_idx_ff + IDX_W'(1);
         end
         salc_pkg::BACK_IDLE: begin
            q_pop = q_valid;
         end
         salc_pkg::BACK_UPDATE: begin
            mem_we       = 1'b1;
            rsp_valid_in = 1'b1;
         end
         default: begin
            clear_active = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= salc_pkg::BACK_CLEAR;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_mem[mem_waddr] <= mem_wdata;
      end
      row_rd_ff <= row_mem[q_set];
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_set_ff <= q_set;
         cur_tag_ff <= q_tag;
      end
      if (rsp_valid_in) begin
         rsp_hit_ff     <= is_hit;
         rsp_way_ff     <= 2'(chosen_idx);
         rsp_evicted_ff <= is_evict;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hit     = rsp_hit_ff;
   assign rsp_way     = rsp_way_ff;
   assign rsp_evicted = rsp_evicted_ff;

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_evicted_ff))
      else $error("response flags both hit and eviction");

   a_rsp_after_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == salc_pkg::BACK_UPDATE))
      else $error("response without an update cycle");

   a_pop_then_update: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == salc_pkg::BACK_UPDATE))
      else $error("popped request not carried out");

   a_victim_unique: assert property (@(posedge clock) disable iff (reset)
      (state_ff == salc_pkg::BACK_UPDATE) |-> ($onehot(victim_oh) && $onehot0(hit_oh)))
      else $error("way selection not unique");

endmodule

`default_nettype wire

// ===== design/set_assoc_lru_cache_lookup_core.sv =====
// Top level of the set-associative cache lookup core with true LRU replacement.
// Flow: a request is queued, popped by the back end in IDLE, carried out in UPDATE,
// and its response is registered. The back end works on one request at a time,
// each a read-then-write of one set row (registered read, then compare, LRU update and write back).
// Reset: synchronous; a clearing pass then writes every set row (64 by default),
// with busy high. The receiver cannot stall responses.
`default_nettype none

module set_assoc_lru_cache_lookup_core #(
   parameter int WAYS       = salc_pkg::WAYS_DEF,
   parameter int SETS       = salc_pkg::SETS_DEF,
   parameter int LINE_BYTES = salc_pkg::LINE_BYTES_DEF,
   parameter int ADDR_BITS  = salc_pkg::ADDR_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [salc_pkg::ADDR_IN_W-1:0] req_address,
   // response channel
   output logic                                rsp_valid,
   output logic                                rsp_hit,
   output logic [1:0]                          rsp_way,
   output logic                                rsp_evicted
);

   // SETS and LINE_BYTES must be powers of two, which the block does not check; the set
   // index and tag are then plain bit fields of the line number.
   localparam int IDX_W = salc_pkg::idx_width(SETS);
   localparam int TAG_W = salc_pkg::tag_width(SETS, LINE_BYTES, ADDR_BITS);

   logic             clear_active;
   logic             q_valid;
   logic             q_pop;
   logic [IDX_W-1:0] q_set;
   logic [TAG_W-1:0] q_tag;

   // Front: decode the address and hold requests in a short queue, so
   // start is taken while the back end is still working on a set.
   salc_front #(
      .WAYS       (WAYS),
      .SETS       (SETS),
      .LINE_BYTES (LINE_BYTES),
      .ADDR_BITS  (ADDR_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_address  (req_address),
      .clear_active (clear_active),
      .q_valid      (q_valid),
      .q_pop        (q_pop),
      .q_set        (q_set),
      .q_tag        (q_tag)
   );

   // Back: read the set row, compare the ways in parallel, advance the
   // LRU ranks, write the row back and register the response.
   salc_back #(
      .WAYS       (WAYS),
      .SETS       (SETS),
      .LINE_BYTES (LINE_BYTES),
      .ADDR_BITS  (ADDR_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .clear_active (clear_active),
      .q_valid      (q_valid),
      .q_pop        (q_pop),
      .q_set        (q_set),
      .q_tag        (q_tag),
      .rsp_valid    (rsp_valid),
      .rsp_hit      (rsp_hit),
      .rsp_way      (rsp_way),
      .rsp_evicted  (rsp_evicted)
   );

endmodule

`default_nettype wire
